// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ===== sv/dgsm_pkg.sv =====
// ---------------------------------------------------------------------------
// Distance gain mixer package
// Shared constants, codes and types of the distance gain speaker mixer.
// ---------------------------------------------------------------------------
`default_nettype none
package dgsm_pkg;

	// Default sizes handed to the top level.
	localparam int DEF_MAX_SOURCES  = 8;
	localparam int DEF_MAX_SPEAKERS = 16;
	localparam int DEF_MAX_BLOCK    = 4096;

	// Results per item never exceed this many speakers.
	localparam int SPK_CAP = 16;

	localparam int CNT_W      = 5;
	localparam int ITER_W     = 6;
	localparam int SQRT_STEPS = 17;
	localparam int LOG_STEPS  = 16;
	localparam int DIV_STEPS  = 58;

	localparam logic [30:0] LOG10_2_Q32 = 31'd1292913987;
	localparam logic [13:0] DA_FLOOR    = 14'd82;
	localparam logic [13:0] DA_ONE      = 14'd8192;

	// Item operation codes.
	localparam logic [1:0] OP_SET_SOURCE  = 2'd0;
	localparam logic [1:0] OP_SET_SPEAKER = 2'd1;
	localparam logic [1:0] OP_SAMPLE      = 2'd2;
	localparam logic [1:0] OP_END_BLOCK   = 2'd3;

	// Mode codes; the remaining codes give silence.
	localparam logic [1:0] MODE_MIX    = 2'd0;
	localparam logic [1:0] MODE_BYPASS = 2'd2;

	// Register indexes.
	localparam logic [3:0] CFG_MODE       = 4'd0;
	localparam logic [3:0] CFG_SRC_COUNT  = 4'd1;
	localparam logic [3:0] CFG_SPK_COUNT  = 4'd2;
	localparam logic [3:0] CFG_MAX_HEIGHT = 4'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  source_count;
		logic [4:0]  speaker_count;
		logic [15:0] max_height;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] ns_src;
		logic [CNT_W-1:0] ns_spk;
	} count_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [3:0]         index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [15:0]        height;
		logic               muted;
		logic signed [23:0] sample;
		logic               last_source;
	} item_t;

	typedef struct packed {
		logic               kind;
		logic [3:0]         speaker;
		logic signed [23:0] mixed_sample;
		logic [46:0]        level;
		logic               last;
	} res_t;

	// Datapath commands.
	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_WR_SRC,
		CMD_WR_SPK,
		CMD_WR_SAMPLE,
		CMD_ACC_CLR,
		CMD_DIFF,
		CMD_SQX,
		CMD_SQY,
		CMD_SQRT,
		CMD_PROD,
		CMD_NORM_INIT,
		CMD_NORM,
		CMD_LOG_INIT,
		CMD_LOG,
		CMD_SCALE,
		CMD_MAC,
		CMD_ROUND,
		CMD_ESQ,
		CMD_EADD,
		CMD_DIV_INIT,
		CMD_DIV,
		CMD_OUT_MIX,
		CMD_OUT_LVL,
		CMD_FRAME_END,
		CMD_BLOCK_END
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic [CNT_W-1:0]  spk;
		logic [CNT_W-1:0]  src;
		logic [ITER_W-1:0] iter;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic counted;
		logic fc_zero;
		logic da_full;
		logic norm_done;
		logic sample_zero;
		logic muted;
	} status_t;

endpackage
`default_nettype wire

// ===== sv/dgsm_if.sv =====
// ---------------------------------------------------------------------------
// Distance gain mixer channels
// Valid/ready channels for items, results and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface dgsm_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [3:0]         index;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [15:0]        height;
	logic               muted;
	logic signed [23:0] sample;
	logic               last_source;

	modport source (output valid, op, index, pos_x, pos_y, height, muted, sample,
		last_source, input ready);
	modport sink (input valid, op, index, pos_x, pos_y, height, muted, sample,
		last_source, output ready);
endinterface

interface dgsm_out_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [3:0]         speaker;
	logic signed [23:0] mixed_sample;
	logic [46:0]        level;
	logic               last;

	modport source (output valid, kind, speaker, mixed_sample, level, last, input ready);
	modport sink (input valid, kind, speaker, mixed_sample, level, last, output ready);
endinterface

interface dgsm_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/dgsm_ctrl.sv =====
// ---------------------------------------------------------------------------
// Distance gain mixer controller
// Sequences items, source/speaker pairs and iterative steps of the datapath.
// ---------------------------------------------------------------------------
`default_nettype none
module dgsm_ctrl import dgsm_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	input  wire cfg_t    cfg,
	input  wire count_t  counts,
	input  wire status_t status,
	output cmd_t         cmd
);

	typedef enum logic [18:0] {
		S_IDLE  = 19'h00001,
		S_SPK   = 19'h00002,
		S_PAIR  = 19'h00004,
		S_SQX   = 19'h00008,
		S_SQY   = 19'h00010,
		S_SQRT  = 19'h00020,
		S_PROD  = 19'h00040,
		S_DA    = 19'h00080,
		S_NORM  = 19'h00100,
		S_LOG   = 19'h00200,
		S_SCALE = 19'h00400,
		S_MAC   = 19'h00800,
		S_ROUND = 19'h01000,
		S_ESQ   = 19'h02000,
		S_EADD  = 19'h04000,
		S_EMIT  = 19'h08000,
		S_BLK   = 19'h10000,
		S_DIV   = 19'h20000,
		S_LVL   = 19'h40000
	} state_t;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  spk_q, spk_d, src_q, src_d;
	logic [ITER_W-1:0] iter_q, iter_d;

	// Next state and command decode.
	always_comb begin
		state_d    = state_q;
		spk_d      = spk_q;
		src_d      = src_q;
		iter_d     = iter_q;
		item_ready = 1'b0;
		cmd.op     = CMD_NONE;
		cmd.spk    = spk_q;
		cmd.src    = src_q;
		cmd.iter   = iter_q;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					unique case (item.op)
						OP_SET_SOURCE:  cmd.op = CMD_WR_SRC;
						OP_SET_SPEAKER: cmd.op = CMD_WR_SPK;
						OP_SAMPLE: begin
							cmd.op = CMD_WR_SAMPLE;
							if (item.last_source) begin
								spk_d   = '0;
								state_d = S_SPK;
							end
						end
						OP_END_BLOCK: begin
							if (cfg.mode == MODE_BYPASS) begin
								cmd.op = CMD_BLOCK_END;
							end else begin
								spk_d   = '0;
								state_d = S_BLK;
							end
						end
						default: ;
					endcase
				end
			end
			S_SPK: begin
				if (spk_q >= counts.ns_spk) begin
					cmd.op  = CMD_FRAME_END;
					state_d = S_IDLE;
				end else begin
					cmd.op = CMD_ACC_CLR;
					src_d  = '0;
					if (cfg.mode == MODE_MIX && !status.muted) state_d = S_PAIR;
					else state_d = S_ROUND;
				end
			end
			S_PAIR: begin
				if (src_q >= counts.ns_src) begin
					state_d = S_ROUND;
				end else if (status.sample_zero) begin
					src_d = src_q + 5'd1;
				end else begin
					cmd.op  = CMD_DIFF;
					state_d = S_SQX;
				end
			end
			S_SQX: begin
				cmd.op  = CMD_SQX;
				state_d = S_SQY;
			end
			S_SQY: begin
				cmd.op  = CMD_SQY;
				iter_d  = ITER_W'(SQRT_STEPS - 1);
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = CMD_SQRT;
				if (iter_q == '0) state_d = S_PROD;
				else iter_d = iter_q - 6'd1;
			end
			S_PROD: begin
				cmd.op  = CMD_PROD;
				state_d = S_DA;
			end
			S_DA: begin
				// A full-scale weight gives zero gain and adds nothing.
				if (status.da_full) begin
					src_d   = src_q + 5'd1;
					state_d = S_PAIR;
				end else begin
					cmd.op  = CMD_NORM_INIT;
					state_d = S_NORM;
				end
			end
			S_NORM: begin
				if (status.norm_done) begin
					cmd.op  = CMD_LOG_INIT;
					iter_d  = ITER_W'(LOG_STEPS - 1);
					state_d = S_LOG;
				end else begin
					cmd.op = CMD_NORM;
				end
			end
			S_LOG: begin
				cmd.op = CMD_LOG;
				if (iter_q == '0) state_d = S_SCALE;
				else iter_d = iter_q - 6'd1;
			end
			S_SCALE: begin
				cmd.op  = CMD_SCALE;
				state_d = S_MAC;
			end
			S_MAC: begin
				cmd.op  = CMD_MAC;
				src_d   = src_q + 5'd1;
				state_d = S_PAIR;
			end
			S_ROUND: begin
				cmd.op = CMD_ROUND;
				if (status.counted && cfg.mode != MODE_BYPASS) state_d = S_ESQ;
				else state_d = S_EMIT;
			end
			S_ESQ: begin
				cmd.op  = CMD_ESQ;
				state_d = S_EADD;
			end
			S_EADD: begin
				cmd.op  = CMD_EADD;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.op  = CMD_OUT_MIX;
					spk_d   = spk_q + 5'd1;
					state_d = S_SPK;
				end
			end
			S_BLK: begin
				if (spk_q >= counts.ns_spk) begin
					cmd.op  = CMD_BLOCK_END;
					state_d = S_IDLE;
				end else begin
					cmd.op = CMD_DIV_INIT;
					iter_d = ITER_W'(DIV_STEPS - 1);
					if (status.fc_zero) state_d = S_LVL;
					else state_d = S_DIV;
				end
			end
			S_DIV: begin
				cmd.op = CMD_DIV;
				if (iter_q == '0) state_d = S_LVL;
				else iter_d = iter_q - 6'd1;
			end
			S_LVL: begin
				if (status.out_free) begin
					cmd.op  = CMD_OUT_LVL;
					spk_d   = spk_q + 5'd1;
					state_d = S_BLK;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			spk_q   <= '0;
			src_q   <= '0;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			spk_q   <= spk_d;
			src_q   <= src_d;
			iter_q  <= iter_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/dgsm_datapath.sv =====
// ---------------------------------------------------------------------------
// Distance gain mixer datapath
// Tables, gain arithmetic, accumulation, energy, division and result register.
// ---------------------------------------------------------------------------
`default_nettype none
module dgsm_datapath import dgsm_pkg::*; #(
	parameter int MAX_SOURCES  = DEF_MAX_SOURCES,
	parameter int MAX_SPEAKERS = DEF_MAX_SPEAKERS,
	parameter int MAX_BLOCK    = DEF_MAX_BLOCK
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire item_t  item,
	input  wire cfg_t   cfg,
	input  wire count_t counts,
	input  wire cmd_t   cmd,
	output status_t     status,
	input  wire logic   res_ready,
	output logic        res_valid,
	output res_t        res
);

	localparam int SRC_IW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int SPK_IW = (MAX_SPEAKERS > 1) ? $clog2(MAX_SPEAKERS) : 1;
	localparam int FC_CAP = (MAX_BLOCK < 8191) ? MAX_BLOCK : 8191;

	// Tables and block state.
	logic signed [15:0] src_x_q [MAX_SOURCES];
	logic signed [15:0] src_y_q [MAX_SOURCES];
	logic [15:0]        src_h_q [MAX_SOURCES];
	logic signed [15:0] spk_x_q [MAX_SPEAKERS];
	logic signed [15:0] spk_y_q [MAX_SPEAKERS];
	logic               spk_mute_q [MAX_SPEAKERS];
	logic signed [23:0] fs_q [MAX_SOURCES];
	logic [57:0]        energy_q [MAX_SPEAKERS];
	logic [12:0]        fc_q;

	// Working registers.
	logic signed [16:0] dx_q, dy_q, di_q;
	logic [33:0]        n_q;
	logic [34:0]        r_q;
	logic [13:0]        da_q;
	logic [12:0]        m_q;
	logic [2:0]         e_q;
	logic [31:0]        x_q;
	logic [15:0]        frac_q;
	logic [14:0]        gain_q;
	logic signed [43:0] acc_q;
	logic signed [23:0] v_q;
	logic [46:0]        sq_q;
	logic [57:0]        dvd_q, quo_q;
	logic [12:0]        rem_q;
	logic               out_valid_q;
	res_t               res_q;

	logic [SRC_IW-1:0]  src_i, wsrc_i, byp_i;
	logic [SPK_IW-1:0]  spk_i, wspk_i;
	logic               wsrc_ok, wspk_ok, counted;
	logic signed [23:0] sel_fs;
	logic signed [33:0] dx_sq, dy_sq;
	logic [34:0]        sq_bit, trial;
	logic signed [34:0] prod_p;
	logic [13:0]        da_d;
	logic [63:0]        x_sq;
	logic [31:0]        x_next;
	logic [2:0]         e_inc;
	logic [18:0]        neg;
	logic [50:0]        scaled;
	logic signed [39:0] mac_p;
	logic signed [43:0] rounded;
	logic signed [23:0] sat_v;
	logic signed [47:0] v_sq;
	logic [58:0]        e_sum;
	logic [13:0]        div_sh;

	assign src_i   = SRC_IW'(cmd.src);
	assign spk_i   = SPK_IW'(cmd.spk);
	assign byp_i   = SRC_IW'(cmd.spk);
	assign wsrc_i  = SRC_IW'(item.index);
	assign wspk_i  = SPK_IW'(item.index);
	assign wsrc_ok = {1'b0, item.index} < 5'(MAX_SOURCES);
	assign wspk_ok = {2'b00, item.index} < 6'(MAX_SPEAKERS);
	assign sel_fs  = fs_q[src_i];
	assign counted = fc_q < 13'(FC_CAP);

	// Distance squares and one restoring square-root step.
	always_comb begin
		dx_sq  = dx_q * dx_q;
		dy_sq  = dy_q * dy_q;
		sq_bit = 35'd1 << {cmd.iter[4:0], 1'b0};
		trial  = r_q + sq_bit;
	end

	// Distance times height margin, clamped into the weight range.
	always_comb begin
		prod_p = $signed({1'b0, r_q[16:0]}) * di_q;
		if (prod_p >= 35'sd67108864) da_d = DA_ONE;
		else if (prod_p[34]) da_d = DA_FLOOR;
		else if ({1'b0, prod_p[25:13]} < DA_FLOOR) da_d = DA_FLOOR;
		else da_d = {1'b0, prod_p[25:13]};
	end

	// One squaring step of the binary logarithm, and the scale to log10.
	always_comb begin
		x_sq   = x_q * x_q;
		x_next = x_sq[61:30];
		e_inc  = e_q + 3'd1;
		neg    = {e_inc, 16'd0} - {3'd0, frac_q};
		scaled = 51'(neg) * 51'(LOG10_2_Q32) + 51'h4_0000_0000;
	end

	// Accumulation, rounding, saturation and energy.
	always_comb begin
		mac_p   = $signed({1'b0, gain_q}) * sel_fs;
		rounded = (acc_q + 44'sd4096) >>> 13;
		if (rounded > 44'sd8388607) sat_v = 24'sh7FFFFF;
		else if (rounded < -44'sd8388608) sat_v = -24'sh800000;
		else sat_v = rounded[23:0];
		v_sq   = v_q * v_q;
		e_sum  = {1'b0, energy_q[spk_i]} + 59'(sq_q);
		div_sh = {rem_q, dvd_q[57]};
	end

	// Tables, frame samples, energy sums and the frame counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SOURCES; i++) begin
				src_x_q[i] <= '0;
				src_y_q[i] <= '0;
				src_h_q[i] <= '0;
				fs_q[i]    <= '0;
			end
			for (int i = 0; i < MAX_SPEAKERS; i++) begin
				spk_x_q[i]    <= '0;
				spk_y_q[i]    <= '0;
				spk_mute_q[i] <= 1'b0;
				energy_q[i]   <= '0;
			end
			fc_q <= '0;
		end else begin
			case (cmd.op)
				CMD_WR_SRC: begin
					if (wsrc_ok) begin
						src_x_q[wsrc_i] <= item.pos_x;
						src_y_q[wsrc_i] <= item.pos_y;
						src_h_q[wsrc_i] <= item.height;
					end
				end
				CMD_WR_SPK: begin
					if (wspk_ok) begin
						spk_x_q[wspk_i]    <= item.pos_x;
						spk_y_q[wspk_i]    <= item.pos_y;
						spk_mute_q[wspk_i] <= item.muted;
					end
				end
				CMD_WR_SAMPLE: begin
					if (wsrc_ok) fs_q[wsrc_i] <= item.sample;
				end
				CMD_EADD: begin
					energy_q[spk_i] <= e_sum[58] ? {58{1'b1}} : e_sum[57:0];
				end
				CMD_FRAME_END: begin
					for (int i = 0; i < MAX_SOURCES; i++) fs_q[i] <= '0;
					if (counted) fc_q <= fc_q + 13'd1;
				end
				CMD_BLOCK_END: begin
					for (int i = 0; i < MAX_SPEAKERS; i++) energy_q[i] <= '0;
					fc_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Arithmetic working registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_ACC_CLR: acc_q <= '0;
			CMD_DIFF: begin
				dx_q <= 17'(src_x_q[src_i]) - 17'(spk_x_q[spk_i]);
				dy_q <= 17'(src_y_q[src_i]) - 17'(spk_y_q[spk_i]);
				di_q <= $signed({1'b0, cfg.max_height}) - $signed({1'b0, src_h_q[src_i]});
			end
			CMD_SQX: n_q <= dx_sq;
			CMD_SQY: begin
				n_q <= n_q + dy_sq;
				r_q <= '0;
			end
			CMD_SQRT: begin
				if ({1'b0, n_q} >= trial) begin
					n_q <= n_q - trial[33:0];
					r_q <= (r_q >> 1) + sq_bit;
				end else begin
					r_q <= r_q >> 1;
				end
			end
			CMD_PROD: da_q <= da_d;
			CMD_NORM_INIT: begin
				m_q <= da_q[12:0];
				e_q <= '0;
			end
			CMD_NORM: begin
				m_q <= m_q << 1;
				e_q <= e_inc;
			end
			CMD_LOG_INIT: begin
				x_q    <= {1'b0, m_q, 18'd0};
				frac_q <= '0;
			end
			CMD_LOG: begin
				if (x_next[31]) begin
					x_q    <= x_next >> 1;
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					x_q    <= x_next;
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			CMD_SCALE: gain_q <= scaled[49:35];
			CMD_MAC: acc_q <= acc_q + 44'(mac_p);
			CMD_ROUND: begin
				// Bypass passes the matching source; other modes take the sum.
				if (cfg.mode == MODE_BYPASS)
					v_q <= (cmd.spk < counts.ns_src) ? fs_q[byp_i] : 24'sd0;
				else
					v_q <= sat_v;
			end
			CMD_ESQ: sq_q <= v_sq[46:0];
			CMD_DIV_INIT: begin
				dvd_q <= energy_q[spk_i];
				rem_q <= '0;
				quo_q <= '0;
			end
			CMD_DIV: begin
				dvd_q <= dvd_q << 1;
				if (div_sh >= {1'b0, fc_q}) begin
					rem_q <= 13'(div_sh - {1'b0, fc_q});
					quo_q <= {quo_q[56:0], 1'b1};
				end else begin
					rem_q <= div_sh[12:0];
					quo_q <= {quo_q[56:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.op == CMD_OUT_MIX) begin
			res_q.kind         <= 1'b0;
			res_q.speaker      <= cmd.spk[3:0];
			res_q.mixed_sample <= v_q;
			res_q.level        <= '0;
			res_q.last         <= (cmd.spk + 5'd1) == counts.ns_spk;
		end else if (cmd.op == CMD_OUT_LVL) begin
			res_q.kind         <= 1'b1;
			res_q.speaker      <= cmd.spk[3:0];
			res_q.mixed_sample <= '0;
			res_q.level        <= quo_q[46:0];
			res_q.last         <= (cmd.spk + 5'd1) == counts.ns_spk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == CMD_OUT_MIX || cmd.op == CMD_OUT_LVL) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res_valid          = out_valid_q;
	assign res                = res_q;
	assign status.out_free    = !out_valid_q || res_ready;
	assign status.counted     = counted;
	assign status.fc_zero     = fc_q == '0;
	assign status.da_full     = da_q[13];
	assign status.norm_done   = m_q[12];
	assign status.sample_zero = sel_fs == 24'sd0;
	assign status.muted       = spk_mute_q[spk_i];

endmodule
`default_nettype wire

// ===== sv/distance_gain_speaker_mixer_core.sv =====
// ---------------------------------------------------------------------------
// Distance gain speaker mixer
// Mixes sources onto speakers with distance-derived gains and reports levels.
// ---------------------------------------------------------------------------
// Geometry items and samples that do not end a frame are taken in the idle
// state. A frame-ending sample then works through the active speakers in
// turn, adding the energy steps when its energy is counted. In mix mode an
// unmuted speaker skips every source with a zero sample and runs every other
// source through the 17-step square root and the 16-step squaring logarithm
// in the shared gain unit; a source whose weight reaches full scale stops
// after the distance. An end-of-block item runs the 58-step restoring
// division of each speaker's energy sum, skipped when the frame count is
// zero, and in bypass mode only clears the block. Each sequence closes with
// a final step. A result that is not taken holds the sequence until the
// output register frees; a new item is taken once the sequence has closed.
`default_nettype none
`include "assert_macros.svh"
module distance_gain_speaker_mixer_core import dgsm_pkg::*; #(
	parameter int MAX_SOURCES  = DEF_MAX_SOURCES,
	parameter int MAX_SPEAKERS = DEF_MAX_SPEAKERS,
	parameter int MAX_BLOCK    = DEF_MAX_BLOCK
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	dgsm_in_if.sink     item,
	dgsm_out_if.source  result,
	dgsm_cfg_if.sink    cfg_wr
);

	localparam int SPK_LIM = (MAX_SPEAKERS < SPK_CAP) ? MAX_SPEAKERS : SPK_CAP;

	cfg_t    cfg_q;
	count_t  counts;
	item_t   item_d;
	cmd_t    cmd;
	status_t status;
	res_t    res;
	logic    res_valid;

	// Configuration registers; every write transaction is taken at once.
	assign cfg_wr.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode          <= MODE_MIX;
			cfg_q.source_count  <= 4'd8;
			cfg_q.speaker_count <= 5'd16;
			cfg_q.max_height    <= 16'd8192;
		end else if (cfg_wr.valid) begin
			unique case (cfg_wr.index)
				CFG_MODE:       cfg_q.mode          <= cfg_wr.data[1:0];
				CFG_SRC_COUNT:  cfg_q.source_count  <= cfg_wr.data[3:0];
				CFG_SPK_COUNT:  cfg_q.speaker_count <= cfg_wr.data[4:0];
				CFG_MAX_HEIGHT: cfg_q.max_height    <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	// Active counts limited to the table sizes, speakers also to SPK_CAP.
	always_comb begin
		if ({1'b0, cfg_q.source_count} > 5'(MAX_SOURCES)) counts.ns_src = 5'(MAX_SOURCES);
		else counts.ns_src = {1'b0, cfg_q.source_count};
		if ({1'b0, cfg_q.speaker_count} > 6'(SPK_LIM)) counts.ns_spk = 5'(SPK_LIM);
		else counts.ns_spk = cfg_q.speaker_count;
	end

	assign item_d.op          = item.op;
	assign item_d.index       = item.index;
	assign item_d.pos_x       = item.pos_x;
	assign item_d.pos_y       = item.pos_y;
	assign item_d.height      = item.height;
	assign item_d.muted       = item.muted;
	assign item_d.sample      = item.sample;
	assign item_d.last_source = item.last_source;

	dgsm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.item       (item_d),
		.cfg        (cfg_q),
		.counts     (counts),
		.status     (status),
		.cmd        (cmd)
	);

	dgsm_datapath #(
		.MAX_SOURCES  (MAX_SOURCES),
		.MAX_SPEAKERS (MAX_SPEAKERS),
		.MAX_BLOCK    (MAX_BLOCK)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_d),
		.cfg       (cfg_q),
		.counts    (counts),
		.cmd       (cmd),
		.status    (status),
		.res_ready (result.ready),
		.res_valid (res_valid),
		.res       (res)
	);

	assign result.valid        = res_valid;
	assign result.kind         = res.kind;
	assign result.speaker      = res.speaker;
	assign result.mixed_sample = res.mixed_sample;
	assign result.level        = res.level;
	assign result.last         = res.last;

	// A level result carries no sample, and a sample result no level.
	`ASSERT_IMPLY(a_level_no_sample, clk, arst_n, result.valid && result.kind, result.mixed_sample == 24'sd0)
	`ASSERT_IMPLY(a_sample_no_level, clk, arst_n, result.valid && !result.kind, result.level == 47'd0)
	// A result is loaded only into a free output register, and then shows.
	`ASSERT_IMPLY(a_emit_slot_free, clk, arst_n, cmd.op == CMD_OUT_MIX || cmd.op == CMD_OUT_LVL, !result.valid || result.ready)
	`ASSERT_NEXT(a_emit_shows, clk, arst_n, cmd.op == CMD_OUT_MIX || cmd.op == CMD_OUT_LVL, result.valid)

endmodule
`default_nettype wire

// ===== tb/tb_distance_gain_speaker_mixer_core.sv =====
// ---------------------------------------------------------------------------
// Distance gain speaker mixer testbench
// Drives geometry, sample and end-of-block transactions and register writes
// into the mixer core. Each result is checked against a behavioural predictor
// of the gain, mixing and level arithmetic or a value typed into the table,
// with random idling on both sides of the item and result channels.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_distance_gain_speaker_mixer_core;
	import dgsm_pkg::*;

	localparam int NSRC      = DEF_MAX_SOURCES;
	localparam int NSPK      = DEF_MAX_SPEAKERS;
	// A short block size lets the frame counter reach its limit quickly.
	localparam int TB_MAX_BLOCK = 16;
	localparam int FRAME_CAP = (TB_MAX_BLOCK < 8191) ? TB_MAX_BLOCK : 8191;
	localparam logic [63:0] ENERGY_SAT = (64'd1 << 58) - 64'd1;
	localparam int SETTLE    = 64;

	// One row of the directed table: a register write or an item.
	typedef struct {
		bit          is_cfg;
		logic [3:0]  reg_idx;
		logic [15:0] reg_val;
		item_t       it;
		bit          typed;
		logic        kind;
		logic [46:0] value;
	} row_t;

	logic clk;
	logic arst_n;

	dgsm_in_if  in_ch();
	dgsm_out_if out_ch();
	dgsm_cfg_if cfg_ch();

	distance_gain_speaker_mixer_core #(
		.MAX_BLOCK (TB_MAX_BLOCK)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.result (out_ch),
		.cfg_wr (cfg_ch)
	);

	// Predictor state and configuration.
	logic [1:0]  p_mode;
	logic [3:0]  p_src_count;
	logic [4:0]  p_spk_count;
	logic [15:0] p_max_height;
	int          src_x [NSRC];
	int          src_y [NSRC];
	int          src_h [NSRC];
	int          spk_x [NSPK];
	int          spk_y [NSPK];
	bit          spk_m [NSPK];
	int          frame_buf [NSRC];
	logic [63:0] energy [NSPK];
	int          frame_count;

	res_t expected_outputs [$];
	int   errors;
	int   send_gap_max;
	int   recv_gap_max;
	row_t rows [$];

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit.
	initial begin
		#(12 * 9000000);
		$display("[distance_gain_speaker_mixer_core] ERROR");
		$finish;
	end

	function automatic logic [63:0] isqrt(input logic [63:0] n_in);
		logic [63:0] n, r, b;
		n = n_in;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Gain -log10(da/8192) in Q.13 through a squaring base-2 logarithm.
	function automatic logic [63:0] gain_for_da(input logic [31:0] da);
		logic [31:0] e, m;
		logic [63:0] x, frac, neg;
		if (da >= 32'd8192) return 64'd0;
		e = 0;
		m = da;
		while (m < 32'd4096) begin
			m = m << 1;
			e = e + 1;
		end
		x = 64'(m) << 18;
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			x = (x * x) >> 30;
			frac = frac << 1;
			if (x >= (64'd1 << 31)) begin
				x = x >> 1;
				frac = frac | 64'd1;
			end
		end
		neg = (64'(1 + e) << 16) - frac;
		return (neg * 64'(LOG10_2_Q32) + (64'd1 << 34)) >> 35;
	endfunction

	function automatic logic [63:0] pair_gain(input int s, input int o);
		longint dx, dy, dlen, di, p;
		logic [31:0] da;
		dx = longint'(src_x[s]) - longint'(spk_x[o]);
		dy = longint'(src_y[s]) - longint'(spk_y[o]);
		dlen = longint'(isqrt(64'(dx * dx + dy * dy)));
		di = longint'(p_max_height) - longint'(src_h[s]);
		p = dlen * di;
		if (p >= (64'sd1 << 26)) da = 32'd8192;
		else if (p < 0) da = 32'd82;
		else begin
			da = 32'(p >>> 13);
			if (da < 32'd82) da = 32'd82;
		end
		return gain_for_da(da);
	endfunction

	function automatic int active_sources();
		return (p_src_count > NSRC) ? NSRC : int'(p_src_count);
	endfunction

	function automatic int active_speakers();
		int n;
		n = p_spk_count;
		if (n > NSPK) n = NSPK;
		if (n > SPK_CAP) n = SPK_CAP;
		return n;
	endfunction

	// Output sample of one speaker for the frame just ended.
	function automatic int speaker_mix(input int o);
		int ns;
		longint acc, r;
		logic [63:0] biased;
		ns = active_sources();
		if (p_mode == MODE_BYPASS) return (o < ns) ? frame_buf[o] : 0;
		if (p_mode != MODE_MIX || spk_m[o]) return 0;
		acc = 0;
		for (int i = 0; i < ns; i++)
			acc += longint'(pair_gain(i, o)) * longint'(frame_buf[i]);
		biased = 64'(acc + 4096 + (64'sd1 << 50));
		r = longint'(biased >> 13) - (64'sd1 << 37);
		if (r > 8388607) r = 8388607;
		if (r < -8388608) r = -8388608;
		return int'(r);
	endfunction

	// Updates the predicted state for one item and, if asked, queues its results.
	task automatic predict_mixer_item(input item_t it, input bit push);
		int ns, v;
		bit counted;
		logic [63:0] sq, lv;
		res_t r;
		ns = active_speakers();
		case (it.op)
			OP_SET_SOURCE: begin
				if (it.index < NSRC) begin
					src_x[it.index] = it.pos_x;
					src_y[it.index] = it.pos_y;
					src_h[it.index] = it.height;
				end
			end
			OP_SET_SPEAKER: begin
				if (it.index < NSPK) begin
					spk_x[it.index] = it.pos_x;
					spk_y[it.index] = it.pos_y;
					spk_m[it.index] = it.muted;
				end
			end
			OP_SAMPLE: begin
				if (it.index < NSRC) frame_buf[it.index] = it.sample;
				if (it.last_source) begin
					counted = frame_count < FRAME_CAP;
					for (int o = 0; o < ns; o++) begin
						v = speaker_mix(o);
						if (counted && p_mode != MODE_BYPASS) begin
							sq = 64'(longint'(v) * longint'(v));
							energy[o] = (energy[o] > ENERGY_SAT - sq) ? ENERGY_SAT
								: energy[o] + sq;
						end
						r.kind = 1'b0;
						r.speaker = 4'(o);
						r.mixed_sample = 24'(v);
						r.level = '0;
						r.last = (o + 1 == ns);
						if (push) expected_outputs.push_back(r);
					end
					if (counted) frame_count++;
					foreach (frame_buf[i]) frame_buf[i] = 0;
				end
			end
			default: begin
				if (p_mode != MODE_BYPASS) begin
					for (int o = 0; o < ns; o++) begin
						lv = frame_count ? energy[o] / 64'(frame_count) : 64'd0;
						r.kind = 1'b1;
						r.speaker = 4'(o);
						r.mixed_sample = '0;
						r.level = lv[46:0];
						r.last = (o + 1 == ns);
						if (push) expected_outputs.push_back(r);
					end
				end
				foreach (energy[i]) energy[i] = 0;
				frame_count = 0;
			end
		endcase
	endtask

	// Queues results typed into the table: one per active speaker, same value.
	task automatic push_typed(input logic kind, input logic [46:0] value);
		int ns;
		res_t r;
		ns = active_speakers();
		for (int o = 0; o < ns; o++) begin
			r.kind = kind;
			r.speaker = 4'(o);
			r.mixed_sample = kind ? 24'd0 : value[23:0];
			r.level = kind ? value : 47'd0;
			r.last = (o + 1 == ns);
			expected_outputs.push_back(r);
		end
	endtask

	// Item transaction; entered and left at a falling edge.
	task automatic send_item(input item_t it, input bit typed, input logic kind,
		input logic [46:0] value);
		int gap;
		gap = $urandom_range(send_gap_max, 0);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.op = it.op;
		in_ch.index = it.index;
		in_ch.pos_x = it.pos_x;
		in_ch.pos_y = it.pos_y;
		in_ch.height = it.height;
		in_ch.muted = it.muted;
		in_ch.sample = it.sample;
		in_ch.last_source = it.last_source;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		predict_mixer_item(it, !typed);
		if (typed) push_typed(kind, value);
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	// Register write, made only once the block has gone quiet.
	task automatic write_reg(input logic [3:0] idx, input logic [15:0] val);
		in_ch.valid = 1'b0;
		while (expected_outputs.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_ch.index = idx;
		cfg_ch.data = val;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_MODE:       p_mode = val[1:0];
			CFG_SRC_COUNT:  p_src_count = val[3:0];
			CFG_SPK_COUNT:  p_spk_count = val[4:0];
			CFG_MAX_HEIGHT: p_max_height = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic item_t mk(input logic [1:0] op, input logic [3:0] idx,
		input logic [15:0] x, input logic [15:0] y, input logic [15:0] h,
		input logic m, input logic [23:0] s, input logic l);
		item_t it;
		it.op = op;
		it.index = idx;
		it.pos_x = x;
		it.pos_y = y;
		it.height = h;
		it.muted = m;
		it.sample = s;
		it.last_source = l;
		return it;
	endfunction

	function automatic item_t random_item();
		return mk(2'($urandom), 4'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 1'($urandom), 24'($urandom), 1'($urandom));
	endfunction

	function automatic logic [23:0] random_sample();
		case ($urandom_range(5, 0))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'(int'($urandom_range(2000, 0)) - 1000);
			3: return 24'd0;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic add_item(input item_t it);
		row_t r;
		r.is_cfg = 1'b0;
		r.reg_idx = '0;
		r.reg_val = '0;
		r.it = it;
		r.typed = 1'b0;
		r.kind = 1'b0;
		r.value = '0;
		rows.push_back(r);
	endtask

	task automatic add_typed(input item_t it, input logic kind, input logic [46:0] value);
		row_t r;
		r.is_cfg = 1'b0;
		r.reg_idx = '0;
		r.reg_val = '0;
		r.it = it;
		r.typed = 1'b1;
		r.kind = kind;
		r.value = value;
		rows.push_back(r);
	endtask

	task automatic add_cfg(input logic [3:0] idx, input logic [15:0] val);
		row_t r;
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		r.it = '0;
		r.typed = 1'b0;
		r.kind = 1'b0;
		r.value = '0;
		rows.push_back(r);
	endtask

	// Result receiver: a random stall before each transaction.
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = $urandom_range(recv_gap_max, 0);
			if (gap > 0) begin
				out_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			@(negedge clk);
		end
	end

	// Result checker against the oldest expectation.
	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_outputs.size() == 0) begin
				$error("unexpected result: speaker %0d", out_ch.speaker);
				errors++;
			end else begin
				e = expected_outputs.pop_front();
				if (out_ch.kind !== e.kind) begin
					$error("kind: expected %0d, actual %0d", e.kind, out_ch.kind);
					errors++;
				end
				if (out_ch.speaker !== e.speaker) begin
					$error("speaker: expected %0d, actual %0d", e.speaker, out_ch.speaker);
					errors++;
				end
				if (out_ch.mixed_sample !== e.mixed_sample) begin
					$error("mixed_sample: expected %0d, actual %0d", e.mixed_sample,
						out_ch.mixed_sample);
					errors++;
				end
				if (out_ch.level !== e.level) begin
					$error("level: expected %0d, actual %0d", e.level, out_ch.level);
					errors++;
				end
				if (out_ch.last !== e.last) begin
					$error("last: expected %0d, actual %0d", e.last, out_ch.last);
					errors++;
				end
			end
		end
	end

	// Stimulus.
	initial begin
		int ns, sent, pick;
		errors = 0;
		send_gap_max = 11;
		recv_gap_max = 11;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.op = '0;
		in_ch.index = '0;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		in_ch.height = '0;
		in_ch.muted = 1'b0;
		in_ch.sample = '0;
		in_ch.last_source = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		p_mode = 2'd0;
		p_src_count = 4'd8;
		p_spk_count = 5'd16;
		p_max_height = 16'd8192;
		foreach (src_x[i]) begin
			src_x[i] = 0; src_y[i] = 0; src_h[i] = 0; frame_buf[i] = 0;
		end
		foreach (spk_x[i]) begin
			spk_x[i] = 0; spk_y[i] = 0; spk_m[i] = 0; energy[i] = 0;
		end
		frame_count = 0;

		// Directed table.
		add_typed(mk(OP_END_BLOCK, 0, 0, 0, 0, 0, 0, 0), 1'b1, 47'd0);
		add_item(mk(OP_SET_SOURCE, 0, 16'd8192, 16'd0, 16'd0, 0, 0, 0));
		add_item(mk(OP_SET_SOURCE, 7, 16'h8000, 16'h7FFF, 16'hFFFF, 0, 0, 0));
		add_item(mk(OP_SET_SOURCE, 9, 16'h7FFF, 16'h7FFF, 16'd0, 0, 0, 0));
		add_item(mk(OP_SET_SPEAKER, 0, 16'd0, 16'd0, 16'd0, 0, 0, 0));
		add_item(mk(OP_SET_SPEAKER, 15, 16'h7FFF, 16'h8000, 16'd0, 1, 0, 0));
		add_item(mk(OP_SAMPLE, 0, 0, 0, 0, 0, 24'h7FFFFF, 0));
		add_item(mk(OP_SAMPLE, 7, 0, 0, 0, 0, 24'h800000, 0));
		// A sample for an absent source still ends the frame.
		add_item(mk(OP_SAMPLE, 12, 0, 0, 0, 0, 24'd12345, 1));
		add_item(mk(OP_SAMPLE, 0, 0, 0, 0, 0, 24'h800000, 1));
		add_item(mk(OP_END_BLOCK, 0, 0, 0, 0, 0, 0, 0));
		add_cfg(CFG_MODE, 16'd1);
		add_typed(mk(OP_SAMPLE, 0, 0, 0, 0, 0, 24'h7FFFFF, 1), 1'b0, 47'd0);
		add_cfg(CFG_MODE, 16'd3);
		add_typed(mk(OP_SAMPLE, 1, 0, 0, 0, 0, 24'h800000, 1), 1'b0, 47'd0);
		add_cfg(CFG_MODE, 16'd2);
		add_item(mk(OP_SAMPLE, 0, 0, 0, 0, 0, 24'd777, 0));
		add_item(mk(OP_SAMPLE, 7, 0, 0, 0, 0, 24'h800000, 1));
		add_item(mk(OP_END_BLOCK, 0, 0, 0, 0, 0, 0, 0));
		add_cfg(CFG_MODE, 16'd0);
		add_cfg(CFG_SRC_COUNT, 16'd15);
		add_cfg(CFG_SPK_COUNT, 16'd31);
		add_cfg(CFG_MAX_HEIGHT, 16'hFFFF);
		add_item(mk(OP_SAMPLE, 7, 0, 0, 0, 0, 24'h7FFFFF, 1));
		add_cfg(CFG_MAX_HEIGHT, 16'd0);
		add_item(mk(OP_SAMPLE, 0, 0, 0, 0, 0, 24'h7FFFFF, 1));
		add_cfg(CFG_SPK_COUNT, 16'd0);
		add_item(mk(OP_SAMPLE, 0, 0, 0, 0, 0, 24'd5, 1));
		add_item(mk(OP_END_BLOCK, 0, 0, 0, 0, 0, 0, 0));

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) write_reg(rows[i].reg_idx, rows[i].reg_val);
			else send_item(rows[i].it, rows[i].typed, rows[i].kind, rows[i].value);
		end

		// Long block: the frame counter stops at its limit.
		write_reg(CFG_SRC_COUNT, 16'd1);
		write_reg(CFG_SPK_COUNT, 16'd1);
		write_reg(CFG_MAX_HEIGHT, 16'd8192);
		send_item(mk(OP_SET_SOURCE, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0);
		send_item(mk(OP_SET_SPEAKER, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0);
		send_item(mk(OP_END_BLOCK, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0);
		send_gap_max = 0;
		recv_gap_max = 0;
		repeat (FRAME_CAP + 8)
			send_item(mk(OP_SAMPLE, 0, 0, 0, 0, 0, 24'h800000, 1), 0, 0, 0);
		send_item(mk(OP_END_BLOCK, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0);

		// Random phases, each under its own setting.
		for (int ph = 0; ph < 12; ph++) begin
			send_gap_max = (ph % 3 == 2) ? 0 : 11;
			recv_gap_max = (ph % 4 == 3) ? 0 : 11;
			write_reg(CFG_MODE, (ph < 8) ? 16'(ph % 4) : 16'($urandom_range(3, 0)));
			case ($urandom_range(4, 0))
				0: write_reg(CFG_SRC_COUNT, 16'd1);
				1: write_reg(CFG_SRC_COUNT, 16'd8);
				2: write_reg(CFG_SRC_COUNT, 16'(4'($urandom)));
				default: write_reg(CFG_SRC_COUNT, 16'($urandom_range(8, 1)));
			endcase
			case ($urandom_range(5, 0))
				0: write_reg(CFG_SPK_COUNT, 16'd1);
				1: write_reg(CFG_SPK_COUNT, 16'd16);
				2: write_reg(CFG_SPK_COUNT, 16'(5'($urandom)));
				default: write_reg(CFG_SPK_COUNT, 16'($urandom_range(16, 1)));
			endcase
			case ($urandom_range(3, 0))
				0: write_reg(CFG_MAX_HEIGHT, 16'd0);
				1: write_reg(CFG_MAX_HEIGHT, 16'hFFFF);
				default: write_reg(CFG_MAX_HEIGHT, 16'($urandom));
			endcase
			ns = active_sources();
			sent = 0;
			while (sent < 26) begin
				pick = $urandom_range(9, 0);
				if (pick <= 1) begin
					send_item(mk(OP_SET_SOURCE, 4'($urandom_range(9, 0)), 16'($urandom),
						16'($urandom), 16'($urandom), 1'($urandom), 0, 0), 0, 0, 0);
					sent++;
				end else if (pick == 2) begin
					send_item(mk(OP_SET_SPEAKER, 4'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom), 1'($urandom), 0, 0), 0, 0, 0);
					sent++;
				end else if (pick <= 7) begin
					// A well-formed frame, one sample per active source.
					for (int s = 0; s < ns; s++)
						send_item(mk(OP_SAMPLE, 4'(s), 16'($urandom), 16'($urandom),
							16'($urandom), 1'($urandom), random_sample(),
							s == ns - 1), 0, 0, 0);
					sent += ns;
				end else if (pick == 8) begin
					send_item(mk(OP_END_BLOCK, 4'($urandom), 0, 0, 0, 0, 0, 0), 0, 0, 0);
					sent++;
				end else begin
					send_item(random_item(), 0, 0, 0);
					sent++;
				end
			end
		end

		in_ch.valid = 1'b0;
		while (expected_outputs.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0) begin
			$display("[distance_gain_speaker_mixer_core] OK");
		end else begin
			$display("[distance_gain_speaker_mixer_core] ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
